// ===== src/gapp_pkg.sv =====
// ----------------------------------------------------------------------------
// gapp_pkg
// Shared types, constants and tables for the asian path payoff block.
// ----------------------------------------------------------------------------
package gapp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_INITIAL_PRICE   = 3'd0;
  localparam logic [2:0] REG_STRIKE_PRICE    = 3'd1;
  localparam logic [2:0] REG_DRIFT_PER_STEP  = 3'd2;
  localparam logic [2:0] REG_VOL_PER_STEP    = 3'd3;
  localparam logic [2:0] REG_DISCOUNT_FACTOR = 3'd4;
  localparam logic [2:0] REG_AVERAGE_SCALE   = 3'd5;
  localparam logic [2:0] REG_PATH_STEPS      = 3'd6;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [31:0] RST_INITIAL_PRICE   = 32'd6553600;
  localparam logic [31:0] RST_STRIKE_PRICE    = 32'd6553600;
  localparam logic [31:0] RST_DISCOUNT_FACTOR = 32'h8000_0000;

  localparam int ExpIterationsDef = 24;
  localparam int MaxExpIter       = 40;

  // ln 2 in Q.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  // floor(2^59 / LN2_Q30), reciprocal for the exponent split
  localparam logic [29:0] INV_LN2_Q59 = 30'd774541002;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [55:0] SUM_MAX = {56{1'b1}};

  // floor((2^32-1)/i), entry 0 unused
  localparam logic [31:0] RECIP [0:MaxExpIter] = '{
    32'd0,
    32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
    32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
    32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941,
    32'd330382099,  32'd306783378,  32'd286331153,  32'd268435455,
    32'd252645135,  32'd238609294,  32'd226050910,  32'd214748364,
    32'd204522252,  32'd195225786,  32'd186737708,  32'd178956970,
    32'd171798691,  32'd165191049,  32'd159072862,  32'd153391689,
    32'd148102320,  32'd143165576,  32'd138547332,  32'd134217727,
    32'd130150524,  32'd126322567,  32'd122713351,  32'd119304647,
    32'd116080197,  32'd113025455,  32'd110127366,  32'd107374182
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_XMUL, ST_XADD, ST_KMUL, ST_KREM, ST_KCOR, ST_KFIX,
    ST_TMUL, ST_TREC, ST_TCHK, ST_TFIX,
    ST_PMUL, ST_PSHF, ST_SUM,
    ST_AHI, ST_ALO, ST_AVG, ST_DIFF, ST_PHI, ST_PLO, ST_PAY, ST_OUT
  } state_e;

  // operands of the shared multiplier
  typedef struct packed {
    logic               en;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

endpackage

// ===== src/gbm_asian_path_payoff.sv =====
// ----------------------------------------------------------------------------
// gbm_asian_path_payoff
// Geometric brownian motion path stepper with arithmetic asian call payoff.
// ----------------------------------------------------------------------------
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[15:0] normal_sample
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata payoff, final price;
//                                               tuser saturation flag
// cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// each word runs the exponent (XMUL, XADD), the ln2 split (KMUL to KFIX) and
// EXP_ITERATIONS taylor terms (TMUL to TFIX) on the shared multiplier, then the
// price update (PMUL, PSHF, SUM); a path's last word adds average and payoff.
// s_axis_tready is high only while idle; a result waits in the output
// register, and the block stalls before loading it only if that is still full.
// reset is asynchronous and restores the register defaults.
module gbm_asian_path_payoff #(
  parameter int EXP_ITERATIONS = gapp_pkg::ExpIterationsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] normal_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // [31:0] payoff, [63:32] price
  output logic                          m_axis_tuser,   // [0] price, sum or payoff saturated
  input  logic                          cfg_we_i,
  input  logic [gapp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gapp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int IterW = $clog2(EXP_ITERATIONS + 1);
  localparam logic [29:0] LN2_EXT = gapp_pkg::LN2_Q30;

  // configuration
  logic [31:0]        init_q, strike_q, disc_q, scale_q;
  logic signed [31:0] drift_q;
  logic [30:0]        vol_q;
  logic [15:0]        steps_q;

  // path state
  logic [31:0] price_q;
  logic [15:0] count_q;
  logic [55:0] ws_q;
  logic        ovf_q;
  logic        last_q;

  // step datapath
  gapp_pkg::state_e   state_q, state_d;
  logic signed [15:0] z_q;
  logic               neg_q;
  logic [34:0]        dr_q;
  logic [6:0]         dq_q;
  logic signed [7:0]  k_q;
  logic [29:0]        rem_q;
  logic [30:0]        term_q;
  logic [31:0]        e_q;
  logic [IterW-1:0]   it_q;
  logic [29:0]        t_q;
  logic [29:0]        q0_q;
  logic [58:0]        acc_q;
  logic [56:0]        diff_q;
  logic [31:0]        pay_q;
  logic               psat_q;

  // output register
  logic        ovalid_q;
  logic [63:0] odata_q;
  logic        ouser_q;

  gapp_pkg::mul_req_t mreq;
  logic [63:0]        prod;
  logic               accept;
  logic               out_free;

  gapp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .prod_o (prod)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // ---------------- combinational helpers ----------------
  logic signed [34:0] vz_sh;
  logic signed [35:0] x_sum;
  logic [34:0]        x_mag;
  logic [34:0]        kr_now;
  logic [29:0]        t_now;
  logic [29:0]        q0_now;
  logic [36:0]        r_now;
  logic [30:0]        q_now;
  logic signed [8:0]  sh;
  logic [8:0]         nsh;
  logic [63:0]        pr_res;
  logic               pr_sat;
  logic [31:0]        price_new;
  logic [32:0]        add_v;
  logic [56:0]        sum_v;
  logic [56:0]        avg_v;
  logic [58:0]        pay_v;
  logic [15:0]        n_eff;
  logic [16:0]        count_inc;

  always_comb begin
    vz_sh   = 35'(signed'(prod[46:0]) >>> 12);
    x_sum   = 36'(drift_q) + 36'(vz_sh);
    x_mag   = x_sum[35] ? 35'(-x_sum) : x_sum[34:0];
    // remainder left by the quotient estimate, below two ln2
    kr_now  = dr_q - prod[34:0];
    t_now   = prod[59:30];
    q0_now  = prod[61:32];
    r_now   = {7'd0, t_q} - prod[36:0];
    q_now   = {1'b0, q0_q} + ((r_now >= 37'(it_q)) ? 31'd1 : 31'd0);

    sh     = 9'sd30 - 9'(k_q);
    nsh    = 9'(-sh);
    pr_res = '0;
    pr_sat = 1'b0;
    if (sh >= 9'sd64) begin
      pr_res = '0;
    end else if (!sh[8]) begin
      pr_res = prod >> sh[5:0];
      pr_sat = (pr_res[63:32] != '0);
    end else if (prod == '0) begin
      pr_res = '0;
    end else if (nsh >= 9'd32 || prod > 64'(gapp_pkg::U32_MAX >> nsh[4:0])) begin
      pr_sat = 1'b1;
    end else begin
      pr_res = prod << nsh[4:0];
    end
    price_new = pr_sat ? gapp_pkg::U32_MAX : pr_res[31:0];

    add_v = last_q ? {1'b0, price_q} : {price_q, 1'b0};
    sum_v = {1'b0, ws_q} + 57'(add_v);

    avg_v = acc_q[56:0] + 57'(prod[63:32]);
    pay_v = acc_q + 59'(prod[63:31]);

    n_eff     = (steps_q == '0) ? 16'd1 : steps_q;
    count_inc = {1'b0, count_q} + 17'd1;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      gapp_pkg::ST_IDLE: if (accept) state_d = gapp_pkg::ST_XMUL;
      gapp_pkg::ST_XMUL: state_d = gapp_pkg::ST_XADD;
      gapp_pkg::ST_XADD: state_d = gapp_pkg::ST_KMUL;
      gapp_pkg::ST_KMUL: state_d = gapp_pkg::ST_KREM;
      gapp_pkg::ST_KREM: state_d = gapp_pkg::ST_KCOR;
      gapp_pkg::ST_KCOR: state_d = gapp_pkg::ST_KFIX;
      gapp_pkg::ST_KFIX: state_d = gapp_pkg::ST_TMUL;
      gapp_pkg::ST_TMUL: state_d = gapp_pkg::ST_TREC;
      gapp_pkg::ST_TREC: state_d = gapp_pkg::ST_TCHK;
      gapp_pkg::ST_TCHK: state_d = gapp_pkg::ST_TFIX;
      gapp_pkg::ST_TFIX: begin
        if (it_q == IterW'(EXP_ITERATIONS)) state_d = gapp_pkg::ST_PMUL;
        else                                state_d = gapp_pkg::ST_TMUL;
      end
      gapp_pkg::ST_PMUL: state_d = gapp_pkg::ST_PSHF;
      gapp_pkg::ST_PSHF: state_d = gapp_pkg::ST_SUM;
      gapp_pkg::ST_SUM:  state_d = last_q ? gapp_pkg::ST_AHI : gapp_pkg::ST_IDLE;
      gapp_pkg::ST_AHI:  state_d = gapp_pkg::ST_ALO;
      gapp_pkg::ST_ALO:  state_d = gapp_pkg::ST_AVG;
      gapp_pkg::ST_AVG:  state_d = gapp_pkg::ST_DIFF;
      gapp_pkg::ST_DIFF: state_d = gapp_pkg::ST_PHI;
      gapp_pkg::ST_PHI:  state_d = gapp_pkg::ST_PLO;
      gapp_pkg::ST_PLO:  state_d = gapp_pkg::ST_PAY;
      gapp_pkg::ST_PAY:  state_d = gapp_pkg::ST_OUT;
      gapp_pkg::ST_OUT:  if (out_free) state_d = gapp_pkg::ST_IDLE;
      default:           state_d = gapp_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs: ready and multiplier operands ----------------
  always_comb begin
    s_axis_tready = 1'b0;
    mreq          = '0;
    case (state_q)
      gapp_pkg::ST_IDLE: s_axis_tready = 1'b1;
      gapp_pkg::ST_XMUL: begin
        mreq.en = 1'b1;
        mreq.a  = {2'b00, vol_q};
        mreq.b  = 33'(z_q);
      end
      gapp_pkg::ST_KMUL: begin
        // quotient estimate from the top bits of the magnitude
        mreq.en = 1'b1;
        mreq.a  = {1'b0, dr_q[34:3]};
        mreq.b  = {3'b000, gapp_pkg::INV_LN2_Q59};
      end
      gapp_pkg::ST_KREM: begin
        mreq.en = 1'b1;
        mreq.a  = {26'd0, prod[62:56]};
        mreq.b  = {3'b000, LN2_EXT};
      end
      gapp_pkg::ST_TMUL: begin
        mreq.en = 1'b1;
        mreq.a  = {2'b00, term_q};
        mreq.b  = {3'b000, rem_q};
      end
      gapp_pkg::ST_TREC: begin
        mreq.en = 1'b1;
        mreq.a  = {3'b000, t_now};
        mreq.b  = {1'b0, gapp_pkg::RECIP[6'(it_q)]};
      end
      gapp_pkg::ST_TCHK: begin
        mreq.en = 1'b1;
        mreq.a  = {3'b000, q0_now};
        mreq.b  = 33'(it_q);
      end
      gapp_pkg::ST_PMUL: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, price_q};
        mreq.b  = {1'b0, e_q};
      end
      gapp_pkg::ST_AHI: begin
        mreq.en = 1'b1;
        mreq.a  = {9'd0, ws_q[55:32]};
        mreq.b  = {1'b0, scale_q};
      end
      gapp_pkg::ST_ALO: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, ws_q[31:0]};
        mreq.b  = {1'b0, scale_q};
      end
      gapp_pkg::ST_PHI: begin
        mreq.en = 1'b1;
        mreq.a  = {8'd0, diff_q[56:32]};
        mreq.b  = {1'b0, disc_q};
      end
      gapp_pkg::ST_PLO: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, diff_q[31:0]};
        mreq.b  = {1'b0, disc_q};
      end
      default: mreq = '0;
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= gapp_pkg::RST_INITIAL_PRICE;
      strike_q <= gapp_pkg::RST_STRIKE_PRICE;
      drift_q  <= '0;
      vol_q    <= '0;
      disc_q   <= gapp_pkg::RST_DISCOUNT_FACTOR;
      scale_q  <= '0;
      steps_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gapp_pkg::REG_INITIAL_PRICE:   init_q   <= cfg_data_i;
        gapp_pkg::REG_STRIKE_PRICE:    strike_q <= cfg_data_i;
        gapp_pkg::REG_DRIFT_PER_STEP:  drift_q  <= signed'(cfg_data_i);
        gapp_pkg::REG_VOL_PER_STEP:    vol_q    <= cfg_data_i[30:0];
        gapp_pkg::REG_DISCOUNT_FACTOR: disc_q   <= cfg_data_i;
        gapp_pkg::REG_AVERAGE_SCALE:   scale_q  <= cfg_data_i;
        gapp_pkg::REG_PATH_STEPS:      steps_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gapp_pkg::ST_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == gapp_pkg::ST_OUT && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tready)                       ovalid_q <= 1'b0;
      case (state_q)
        gapp_pkg::ST_IDLE: if (accept && count_q == '0) ovf_q <= 1'b0;
        gapp_pkg::ST_PSHF: begin
          count_q <= count_inc[15:0];
          if (pr_sat) ovf_q <= 1'b1;
        end
        gapp_pkg::ST_SUM: if (sum_v > {1'b0, gapp_pkg::SUM_MAX}) ovf_q <= 1'b1;
        gapp_pkg::ST_OUT: if (out_free) count_q <= '0;
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      gapp_pkg::ST_IDLE: begin
        if (accept) begin
          z_q <= signed'(s_axis_tdata);
          if (count_q == '0) begin
            price_q <= init_q;
            ws_q    <= {24'd0, init_q};
          end
        end
      end
      gapp_pkg::ST_XADD: begin
        neg_q <= x_sum[35];
        dr_q  <= x_mag;
      end
      gapp_pkg::ST_KREM: dq_q <= prod[62:56];
      gapp_pkg::ST_KCOR: begin
        // the estimate is at most one below the true quotient
        if (kr_now >= {5'd0, LN2_EXT}) begin
          dr_q <= kr_now - {5'd0, LN2_EXT};
          dq_q <= dq_q + 7'd1;
        end else begin
          dr_q <= kr_now;
        end
      end
      gapp_pkg::ST_KFIX: begin
        // floor for negative exponents
        if (!neg_q) begin
          k_q   <= signed'({1'b0, dq_q});
          rem_q <= dr_q[29:0];
        end else if (dr_q == '0) begin
          k_q   <= -signed'({1'b0, dq_q});
          rem_q <= '0;
        end else begin
          k_q   <= -signed'({1'b0, dq_q}) - 8'sd1;
          rem_q <= LN2_EXT - dr_q[29:0];
        end
        term_q <= gapp_pkg::ONE_Q30;
        e_q    <= {1'b0, gapp_pkg::ONE_Q30};
        it_q   <= IterW'(1);
      end
      gapp_pkg::ST_TREC: t_q  <= t_now;
      gapp_pkg::ST_TCHK: q0_q <= q0_now;
      gapp_pkg::ST_TFIX: begin
        term_q <= q_now;
        e_q    <= e_q + {1'b0, q_now};
        it_q   <= it_q + IterW'(1);
      end
      gapp_pkg::ST_PSHF: begin
        price_q <= price_new;
        last_q  <= (count_inc >= {1'b0, n_eff});
      end
      gapp_pkg::ST_SUM: begin
        ws_q <= (sum_v > {1'b0, gapp_pkg::SUM_MAX}) ? gapp_pkg::SUM_MAX : sum_v[55:0];
      end
      gapp_pkg::ST_ALO: acc_q <= {2'b00, prod[56:0]};
      gapp_pkg::ST_AVG: acc_q <= {2'b00, avg_v};
      gapp_pkg::ST_DIFF: begin
        diff_q <= (acc_q[56:0] > {25'd0, strike_q}) ?
                  acc_q[56:0] - {25'd0, strike_q} : '0;
      end
      gapp_pkg::ST_PLO: acc_q <= {prod[57:0], 1'b0};
      gapp_pkg::ST_PAY: begin
        psat_q <= (pay_v[58:32] != '0);
        pay_q  <= (pay_v[58:32] != '0) ? gapp_pkg::U32_MAX : pay_v[31:0];
      end
      gapp_pkg::ST_OUT: begin
        if (out_free) begin
          odata_q <= {price_q, pay_q};
          ouser_q <= ovf_q || psat_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/gapp_mul.sv =====
// ----------------------------------------------------------------------------
// gapp_mul
// Shared 33 x 33 signed multiplier with a registered 64 bit product.
// ----------------------------------------------------------------------------
module gapp_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gapp_pkg::mul_req_t  req_i,
  output logic [63:0]         prod_o
);

  logic signed [65:0] full;
  logic [63:0]        prod_q;

  assign full   = req_i.a * req_i.b;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (req_i.en) begin
      prod_q <= full[63:0];
    end
  end

endmodule
